FILE: rtl/report_dedup_window_unit_macros.svh
// Assertion macros shared by the report dedup window RTL.
`ifndef REPORT_DEDUP_WINDOW_UNIT_MACROS_SVH
`define REPORT_DEDUP_WINDOW_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RDW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next.
`define RDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rdw_pkg.sv
// Shared constants, types and helper functions of the report dedup window unit.
`default_nettype none

package rdw_pkg;

  // Window geometry
  localparam int SLOTS      = 16;
  localparam int DEPTH      = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int SUM_W      = FILL_W + 1;
  localparam int SLOT_W     = 4;
  localparam int SLOT_IDX_W = (SLOTS <= 2) ? 1 : ((SLOTS >= 16) ? SLOT_W : $clog2(SLOTS));
  localparam int MEM_DEPTH  = SLOTS * DEPTH;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Stream widths
  localparam int CMD_W        = 2;
  localparam int OUTCOME_W    = 3;
  localparam int OUT_FILL_W   = 4;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_REPORT     = 2'd0,
    CMD_CLEAR_SLOT = 2'd1,
    CMD_CLEAR_ALL  = 2'd2
  } cmd_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NEW_ACCEPTED     = 3'd0,
    OUT_RETRY            = 3'd1,
    OUT_CONFLICT         = 3'd2,
    OUT_NEW_REFUSED      = 3'd3,
    OUT_UNKNOWN_FORWARD  = 3'd4,
    OUT_UNKNOWN_REFUSED  = 3'd5,
    OUT_CLEARED          = 3'd6
  } outcome_e;

  // Class of the transaction held in the datapath
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_CLEAR = 2'd1,
    CLS_SCAN  = 2'd2,
    CLS_PASS  = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    V_ABSENT   = 2'd0,
    V_RETRY    = 2'd1,
    V_CONFLICT = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [31:0] event_value;
    logic [7:0]  evt_kind;
    logic [7:0]  src_ep;
    logic [15:0] msg_id;
  } fp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic start_scan;
    logic scan;
    logic publish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cls_e cls;
    logic scan_done;
  } dp_sts_t;

  // Advance a window position by an offset, wrapping at DEPTH.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0]  base,
                                                input logic [FILL_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rdw_ctrl.sv
// Controller state machine of the report dedup window unit.
`default_nettype none
`include "report_dedup_window_unit_macros.svh"

module rdw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_tvalid_i,
  output logic                    in_tready_o,
  output logic                    out_tvalid_o,
  input  wire logic               out_tready_i,
  input  wire rdw_pkg::dp_sts_t   sts_i,
  output rdw_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_tready_o  = (state_q == ST_IDLE);
  assign out_tvalid_o = out_valid_q;
  assign out_free     = !out_valid_q || out_tready_i;

  // Sequence one transaction: take, classify, scan when needed, publish if it has a result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.cls)
          rdw_pkg::CLS_NONE: state_d = ST_IDLE;
          rdw_pkg::CLS_SCAN: begin
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `RDW_ASSERT(a_publish_safe, cmd_o.publish |-> (!out_valid_q || out_tready_i), "result overwritten")
  `RDW_ASSERT_NEXT(a_take_decode, in_tvalid_i && in_tready_o, state_q == ST_DECODE, "no decode after take")
  `RDW_ASSERT_NEXT(a_scan_exit, state_q == ST_SCAN && sts_i.scan_done, state_q == ST_RESULT, "scan did not end")

endmodule

`default_nettype wire

FILE: rtl/rdw_datapath.sv
// Datapath of the report dedup window unit: transaction register, windows, scan.
`default_nettype none
`include "report_dedup_window_unit_macros.svh"

module rdw_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rdw_pkg::ctrl_cmd_t              cmd_i,
  output rdw_pkg::dp_sts_t                     sts_o,
  input  wire logic [rdw_pkg::CMD_W-1:0]       cmd_in_i,
  input  wire logic [rdw_pkg::SLOT_W-1:0]      slot_i,
  input  wire logic                            slot_known_i,
  input  wire rdw_pkg::fp_t                    fp_i,
  input  wire logic                            sink_accepts_i,
  output logic [rdw_pkg::OUTCOME_W-1:0]        outcome_o,
  output logic                                 forward_event_o,
  output logic                                 send_ack_o,
  output logic [rdw_pkg::OUT_FILL_W-1:0]       fill_count_o
);

  // Transaction register
  logic [rdw_pkg::CMD_W-1:0]  cmd_q;
  logic [rdw_pkg::SLOT_W-1:0] slot_q;
  logic                       known_q;
  rdw_pkg::fp_t               fp_q;
  logic                       accepts_q;

  // Window bookkeeping
  logic [rdw_pkg::FILL_W-1:0] fill_q [rdw_pkg::SLOTS];
  logic [rdw_pkg::IDX_W-1:0]  head_q [rdw_pkg::SLOTS];

  // Scan state
  logic [rdw_pkg::FILL_W-1:0] rd_pos_q, rd_pos_d;
  logic                       cmp_vld_q;
  rdw_pkg::verdict_e          verdict_q, verdict_d;

  // Fingerprint memory
  rdw_pkg::fp_t               mem_q [rdw_pkg::MEM_DEPTH];
  rdw_pkg::fp_t               rdata_q;

  logic [rdw_pkg::SLOT_IDX_W-1:0] slot_idx;
  logic                           slot_ok;
  logic [rdw_pkg::FILL_W-1:0]     cur_fill;
  logic [rdw_pkg::IDX_W-1:0]      cur_head;
  logic                           not_full;
  rdw_pkg::cls_e                  cls;
  logic                           id_hit;
  logic                           rd_en;
  logic [rdw_pkg::IDX_W-1:0]      rd_idx;
  logic [rdw_pkg::ADDR_W-1:0]     rd_addr;
  logic                           ins_en;
  logic [rdw_pkg::IDX_W-1:0]      wr_idx;
  logic [rdw_pkg::ADDR_W-1:0]     wr_addr;
  logic [rdw_pkg::FILL_W-1:0]     fill_new;
  logic [rdw_pkg::IDX_W-1:0]      head_new;

  rdw_pkg::outcome_e              outcome_d, outcome_q;
  logic                           fwd_d, fwd_q;
  logic                           ack_d, ack_q;
  logic [rdw_pkg::FILL_W-1:0]     fill_d, fill_out_q;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= cmd_in_i;
      slot_q    <= slot_i;
      known_q   <= slot_known_i;
      fp_q      <= fp_i;
      accepts_q <= sink_accepts_i;
    end
  end

  assign slot_idx = slot_q[rdw_pkg::SLOT_IDX_W-1:0];
  assign slot_ok  = (32'(slot_q) < rdw_pkg::SLOTS);
  assign cur_fill = fill_q[slot_idx];
  assign cur_head = head_q[slot_idx];
  assign not_full = (cur_fill < rdw_pkg::FILL_W'(rdw_pkg::DEPTH));

  // Classify the held transaction
  always_comb begin
    unique case (cmd_q)
      rdw_pkg::CMD_REPORT:     cls = (known_q && slot_ok) ? rdw_pkg::CLS_SCAN : rdw_pkg::CLS_PASS;
      rdw_pkg::CMD_CLEAR_SLOT: cls = rdw_pkg::CLS_CLEAR;
      rdw_pkg::CMD_CLEAR_ALL:  cls = rdw_pkg::CLS_CLEAR;
      default:                 cls = rdw_pkg::CLS_NONE;
    endcase
  end

  // Scan oldest to newest, one read issued and one entry compared per cycle
  assign id_hit          = cmp_vld_q && (rdata_q.msg_id == fp_q.msg_id);
  assign sts_o.cls       = cls;
  assign sts_o.scan_done = id_hit || (rd_pos_q == cur_fill);
  assign rd_en           = cmd_i.scan && !sts_o.scan_done;
  assign rd_idx          = rdw_pkg::wrap_idx(cur_head, rd_pos_q);
  assign rd_addr         = rdw_pkg::ADDR_W'(32'(slot_idx) * rdw_pkg::DEPTH + 32'(rd_idx));

  always_comb begin
    rd_pos_d  = rd_pos_q;
    verdict_d = verdict_q;
    if (cmd_i.start_scan) begin
      rd_pos_d  = '0;
      verdict_d = rdw_pkg::V_ABSENT;
    end else if (cmd_i.scan) begin
      if (id_hit) begin
        verdict_d = (rdata_q == fp_q) ? rdw_pkg::V_RETRY : rdw_pkg::V_CONFLICT;
      end
      if (rd_en) begin
        rd_pos_d = rd_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pos_q  <= '0;
      cmp_vld_q <= 1'b0;
      verdict_q <= rdw_pkg::V_ABSENT;
    end else begin
      rd_pos_q  <= rd_pos_d;
      cmp_vld_q <= rd_en;
      verdict_q <= verdict_d;
    end
  end

  // Append position: next free entry, or the oldest when full
  assign ins_en   = cmd_i.publish && (cls == rdw_pkg::CLS_SCAN) &&
                    (verdict_q == rdw_pkg::V_ABSENT) && accepts_q;
  assign wr_idx   = not_full ? rdw_pkg::wrap_idx(cur_head, cur_fill) : cur_head;
  assign wr_addr  = rdw_pkg::ADDR_W'(32'(slot_idx) * rdw_pkg::DEPTH + 32'(wr_idx));
  assign fill_new = not_full ? cur_fill + 1'b1 : cur_fill;
  assign head_new = not_full ? cur_head : rdw_pkg::wrap_idx(cur_head, rdw_pkg::FILL_W'(1));

  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      mem_q[wr_addr] <= fp_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Update window counts on publish: clear or append
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rdw_pkg::SLOTS; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else if (cmd_i.publish && (cls == rdw_pkg::CLS_CLEAR)) begin
      if (cmd_q == rdw_pkg::CMD_CLEAR_ALL) begin
        for (int i = 0; i < rdw_pkg::SLOTS; i++) begin
          fill_q[i] <= '0;
          head_q[i] <= '0;
        end
      end else if (slot_ok) begin
        fill_q[slot_idx] <= '0;
        head_q[slot_idx] <= '0;
      end
    end else if (ins_en) begin
      fill_q[slot_idx] <= fill_new;
      head_q[slot_idx] <= head_new;
    end
  end

  // Form the result
  always_comb begin
    outcome_d = rdw_pkg::OUT_CLEARED;
    fwd_d     = 1'b0;
    ack_d     = 1'b0;
    fill_d    = '0;
    unique case (cls)
      rdw_pkg::CLS_SCAN: begin
        fill_d = cur_fill;
        unique case (verdict_q)
          rdw_pkg::V_CONFLICT: outcome_d = rdw_pkg::OUT_CONFLICT;
          rdw_pkg::V_RETRY: begin
            outcome_d = rdw_pkg::OUT_RETRY;
            ack_d     = 1'b1;
          end
          default: begin
            if (accepts_q) begin
              outcome_d = rdw_pkg::OUT_NEW_ACCEPTED;
              fwd_d     = 1'b1;
              ack_d     = 1'b1;
              fill_d    = fill_new;
            end else begin
              outcome_d = rdw_pkg::OUT_NEW_REFUSED;
            end
          end
        endcase
      end
      rdw_pkg::CLS_PASS: begin
        if (accepts_q) begin
          outcome_d = rdw_pkg::OUT_UNKNOWN_FORWARD;
          fwd_d     = 1'b1;
          ack_d     = 1'b1;
        end else begin
          outcome_d = rdw_pkg::OUT_UNKNOWN_REFUSED;
        end
      end
      default: outcome_d = rdw_pkg::OUT_CLEARED;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      outcome_q  <= outcome_d;
      fwd_q      <= fwd_d;
      ack_q      <= ack_d;
      fill_out_q <= fill_d;
    end
  end

  assign outcome_o       = outcome_q;
  assign forward_event_o = fwd_q;
  assign send_ack_o      = ack_q;
  assign fill_count_o    = rdw_pkg::OUT_FILL_W'(fill_out_q);

  `RDW_ASSERT(a_scan_bound, cmd_i.scan |-> (rd_pos_q <= cur_fill), "scan ran past fill")
  `RDW_ASSERT(a_cmp_after_scan, cmp_vld_q |-> $past(cmd_i.scan), "compare without read")

endmodule

`default_nettype wire

FILE: rtl/report_dedup_window_unit.sv
// Top level of the report dedup window unit: stream ports, controller and datapath.
//
// Keeps a window of the last 8 report fingerprints for each of 16 device slots
// and classifies each report as new, retry or conflict, or clears windows.
// One transaction is taken at a time and yields one result (the undefined
// command yields none). A report from a known slot reads at most its fill
// count of window entries, fewer when an earlier entry carries the
// same report id: the scan reads one window entry per cycle from the
// single-port 128 x 64 fingerprint memory and stops at the first matching id.
// Clear commands, unknown-origin reports and the undefined command skip the
// scan. A finished result waits in an output register, so the next
// transaction is taken while the sink holds off. Window contents are not
// initialized; fill counts and heads reset to zero, so no start-up pass is
// needed.
`default_nettype none

module report_dedup_window_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // slot[3:0], slot_known[4], msg_id[20:5], src_ep[28:21],
  // evt_kind[36:29], event_value[68:37], sink_accepts[69], zero[71:70]
  input  wire logic [rdw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  wire logic [rdw_pkg::CMD_W-1:0]           s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // forward_event[0], send_ack[1], fill_count[5:2], zero[7:6]
  output logic [rdw_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // outcome[2:0]
  output logic [rdw_pkg::OUTCOME_W-1:0]            m_axis_tuser
);

  rdw_pkg::ctrl_cmd_t                  cmd;
  rdw_pkg::dp_sts_t                    sts;
  rdw_pkg::fp_t                        fp_in;
  logic                                forward_event;
  logic                                send_ack;
  logic [rdw_pkg::OUT_FILL_W-1:0]      fill_count;

  // Unpack the incoming fingerprint
  assign fp_in.msg_id      = s_axis_tdata[20:5];
  assign fp_in.src_ep      = s_axis_tdata[28:21];
  assign fp_in.evt_kind    = s_axis_tdata[36:29];
  assign fp_in.event_value = s_axis_tdata[68:37];

  rdw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_o  (s_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  rdw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cmd_in_i        (s_axis_tuser),
    .slot_i          (s_axis_tdata[3:0]),
    .slot_known_i    (s_axis_tdata[4]),
    .fp_i            (fp_in),
    .sink_accepts_i  (s_axis_tdata[69]),
    .outcome_o       (m_axis_tuser),
    .forward_event_o (forward_event),
    .send_ack_o      (send_ack),
    .fill_count_o    (fill_count)
  );

  // Pack the result
  assign m_axis_tdata = {2'b00, fill_count, send_ack, forward_event};

endmodule

`default_nettype wire

FILE: bench/dedup_window_checker.sv
`timescale 1ns / 1ps
// Checker of the report dedup window unit: predicts every result and compares it.
module dedup_window_checker
  import rdw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [CMD_W-1:0]       s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUTCOME_W-1:0]   m_axis_tuser,
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct {
    outcome_e                outcome;
    logic                    forward;
    logic                    ack;
    logic [OUT_FILL_W-1:0]   fill;
  } verdict_t;

  // Predicted window state
  fp_t               window_mem  [SLOTS][DEPTH];
  logic [FILL_W-1:0] window_fill [SLOTS];
  logic [IDX_W-1:0]  window_head [SLOTS];

  verdict_t expected_verdicts [$];
  int       result_index;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_index  = 0;
    for (int s = 0; s < SLOTS; s++) begin
      window_fill[s] = '0;
      window_head[s] = '0;
    end
  end

  // Print one line for a mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, result_index, what);
    fail_count++;
  endtask

  // Classify one transaction against the windows and update them; 0 when no result follows
  function automatic bit classify_report(input logic [CMD_W-1:0]      cmd,
                                         input logic [IN_TDATA_W-1:0] data,
                                         output verdict_t             v);
    logic [SLOT_W-1:0] slot;
    logic              known;
    logic              accepts;
    fp_t               probe;
    fp_t               entry;
    verdict_e          hit;
    slot    = data[3:0];
    known   = data[4];
    probe   = fp_t'(data[68:5]);
    accepts = data[69];
    v       = '{OUT_CLEARED, 1'b0, 1'b0, '0};
    case (cmd)
      CMD_CLEAR_SLOT: begin
        window_fill[slot] = '0;
        window_head[slot] = '0;
      end
      CMD_CLEAR_ALL: begin
        for (int s = 0; s < SLOTS; s++) begin
          window_fill[s] = '0;
          window_head[s] = '0;
        end
      end
      CMD_REPORT: begin
        if (known) begin
          // Scan oldest to newest; the first matching id decides
          hit = V_ABSENT;
          for (int pos = 0; pos < window_fill[slot] && hit == V_ABSENT; pos++) begin
            entry = window_mem[slot][(int'(window_head[slot]) + pos) % DEPTH];
            if (entry.msg_id == probe.msg_id) begin
              hit = (entry == probe) ? V_RETRY : V_CONFLICT;
            end
          end
          case (hit)
            V_RETRY: begin
              v.outcome = OUT_RETRY;
              v.ack     = 1'b1;
            end
            V_CONFLICT: begin
              v.outcome = OUT_CONFLICT;
            end
            default: begin
              if (accepts) begin
                // Append, overwriting the oldest entry of a full window
                if (window_fill[slot] < DEPTH) begin
                  window_mem[slot][(int'(window_head[slot]) + int'(window_fill[slot])) % DEPTH]
                    = probe;
                  window_fill[slot] = window_fill[slot] + 1'b1;
                end else begin
                  window_mem[slot][window_head[slot]] = probe;
                  window_head[slot] = IDX_W'((int'(window_head[slot]) + 1) % DEPTH);
                end
                v.outcome = OUT_NEW_ACCEPTED;
                v.forward = 1'b1;
                v.ack     = 1'b1;
              end else begin
                v.outcome = OUT_NEW_REFUSED;
              end
            end
          endcase
          v.fill = OUT_FILL_W'(window_fill[slot]);
        end else if (accepts) begin
          v.outcome = OUT_UNKNOWN_FORWARD;
          v.forward = 1'b1;
          v.ack     = 1'b1;
        end else begin
          v.outcome = OUT_UNKNOWN_REFUSED;
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Retire results against the oldest expectation, then predict the new transaction
  always @(posedge clk_i) begin : watch_channels
    verdict_t oldest;
    verdict_t fresh;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, outcome %0d", m_axis_tuser));
        end else begin
          oldest = expected_verdicts.pop_front();
          if (m_axis_tuser !== oldest.outcome) begin
            flag_mismatch($sformatf("outcome got %0d expected %0d",
                                    m_axis_tuser, oldest.outcome));
          end
          if (m_axis_tdata[0] !== oldest.forward) begin
            flag_mismatch($sformatf("forward_event got %0b expected %0b",
                                    m_axis_tdata[0], oldest.forward));
          end
          if (m_axis_tdata[1] !== oldest.ack) begin
            flag_mismatch($sformatf("send_ack got %0b expected %0b",
                                    m_axis_tdata[1], oldest.ack));
          end
          if (m_axis_tdata[5:2] !== oldest.fill) begin
            flag_mismatch($sformatf("fill_count got %0d expected %0d",
                                    m_axis_tdata[5:2], oldest.fill));
          end
          if (m_axis_tdata[7:6] !== 2'b00) begin
            flag_mismatch($sformatf("padding bits got %0b", m_axis_tdata[7:6]));
          end
        end
        result_index++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (classify_report(s_axis_tuser, s_axis_tdata, fresh)) begin
          expected_verdicts.push_back(fresh);
        end
      end
      pending_count = expected_verdicts.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the report dedup window bench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import rdw_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HISTORY      = 12;
  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = CMD_REPORT;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUTCOME_W-1:0]   m_axis_tuser;

  int  fail_count;
  int  pending_count;
  int  sent         = 0;
  int  stall_cycles = 0;
  bit  hold_done    = 1'b0;

  // Fingerprints offered per slot, replayed to provoke retries and conflicts
  fp_t history    [SLOTS][HISTORY];
  int  history_n  [SLOTS];
  int  history_wr [SLOTS];

  always #(CLK_HALF) clk_i = ~clk_i;

  report_dedup_window_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  dedup_window_checker verdict_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic bit calm();
    return sent >= RANDOM_ITEMS - CALM_ITEMS;
  endfunction

  function automatic fp_t fingerprint(logic [15:0] rid, logic [7:0] ep,
                                      logic [7:0] kind, logic [31:0] val);
    return {val, kind, ep, rid};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_report(logic [SLOT_W-1:0] slot, logic known,
                                                        fp_t fp, logic accepts);
    return {2'b00, accepts, fp, known, slot};
  endfunction

  // Offer one transaction from a falling edge and hold it until accepted
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [IN_TDATA_W-1:0] data);
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic offer_report(input logic [SLOT_W-1:0] slot, input logic known,
                              input fp_t fp, input logic accepts);
    offer(CMD_REPORT, pack_report(slot, known, fp, accepts));
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (!calm() && $urandom_range(0, 9) < 3) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // Receiver: random ready bursts, one long hold-off, steady ready at the end
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sent >= HOLD_AT) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!calm() && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("report_dedup_window_unit: mismatch");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic              known;
    logic              accepts;
    fp_t               fp;
    fp_t               old_fp;
    int                pick;
    for (int s = 0; s < SLOTS; s++) begin
      history_n[s]  = 0;
      history_wr[s] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: new, retry, conflict, refusals, unknown origin, ignored command
    offer_report(4'd0, 1'b1, fingerprint(16'h0000, 8'h00, 8'h00, 32'h0), 1'b1);
    offer_report(4'd0, 1'b1, fingerprint(16'h0000, 8'h00, 8'h00, 32'h0), 1'b1);
    offer_report(4'd0, 1'b1, fingerprint(16'h0000, 8'h00, 8'h00, 32'hFFFF_FFFF), 1'b1);
    offer_report(4'd15, 1'b1, fingerprint(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
    offer_report(4'd15, 1'b1, fingerprint(16'h0001, 8'h12, 8'h34, 32'h5678_9ABC), 1'b0);
    offer_report(4'd3, 1'b0, fingerprint(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
    offer_report(4'd3, 1'b0, fingerprint(16'h0000, 8'h00, 8'h00, 32'h0), 1'b0);
    offer(CMD_UNDEFINED, pack_report(4'd15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    sender_gap();

    // Directed: fill slot 2 past its depth so the oldest entry is overwritten
    for (int k = 0; k <= DEPTH; k++) begin
      offer_report(4'd2, 1'b1, fingerprint(16'(10 + k), 8'(k), 8'(k), 32'(k)), 1'b1);
    end
    offer_report(4'd2, 1'b1, fingerprint(16'd10, 8'd0, 8'd0, 32'd0), 1'b1);
    offer_report(4'd2, 1'b1, fingerprint(16'd12, 8'd2, 8'd2, 32'd2), 1'b1);
    offer(CMD_CLEAR_SLOT, pack_report(4'd2, 1'b1, '0, 1'b0));
    offer_report(4'd2, 1'b1, fingerprint(16'd12, 8'd2, 8'd2, 32'd2), 1'b1);
    offer(CMD_CLEAR_ALL, pack_report(4'd0, 1'b0, '0, 1'b0));
    offer_report(4'd15, 1'b1, fingerprint(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1'b1);
    sender_gap();

    // Random: mostly fresh reports and replays of recent ones, some clears and noise
    while (sent < RANDOM_ITEMS) begin
      pick    = $urandom_range(0, 99);
      slot    = SLOT_W'($urandom_range(0, SLOTS - 1));
      fp      = fp_t'({$urandom, $urandom});
      accepts = ($urandom_range(0, 9) != 0);
      known   = 1'b1;
      cmd     = CMD_REPORT;
      if (pick < 4) begin
        cmd   = CMD_CLEAR_SLOT;
        known = 1'($urandom_range(0, 1));
      end else if (pick < 5) begin
        cmd   = CMD_CLEAR_ALL;
        known = 1'($urandom_range(0, 1));
      end else if (pick < 7) begin
        cmd = CMD_UNDEFINED;
      end else if (pick < 12) begin
        known = 1'b0;
      end else if (pick >= 45 && history_n[slot] > 0) begin
        old_fp = history[slot][$urandom_range(0, history_n[slot] - 1)];
        fp     = old_fp;
        // Flip one content bit to turn the replay into a conflict
        if (pick >= 80) begin
          fp[16 + $urandom_range(0, 47)] ^= 1'b1;
        end
      end else begin
        history[slot][history_wr[slot]] = fp;
        history_wr[slot] = (history_wr[slot] + 1) % HISTORY;
        if (history_n[slot] < HISTORY) begin
          history_n[slot]++;
        end
      end
      offer(cmd, pack_report(slot, known, fp, accepts));
      if (cmd != CMD_UNDEFINED) begin
        sent++;
      end
      sender_gap();
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("report_dedup_window_unit: match");
    end else begin
      $display("report_dedup_window_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rdw_pkg.sv
rtl/rdw_ctrl.sv
rtl/rdw_datapath.sv
rtl/report_dedup_window_unit.sv
bench/dedup_window_checker.sv
bench/testbench.sv
